// ===== rtl/rgst_pkg.sv =====
// ----------------------------------------------------------------------------
// rgst_pkg: shared types and constants of the ray grid segment tracer
// Command codes, register indexes, iteration counts and saturating helpers.
// ----------------------------------------------------------------------------
package rgst_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_X = 2'd0,
    CMD_LOAD_Y = 2'd1,
    CMD_TRACE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_CELLS_X = 1'b0,
    REG_CELLS_Y = 1'b1
  } reg_e;

  localparam int unsigned DIV_STEPS  = 65;
  localparam int unsigned SQRT_STEPS = 33;
  localparam logic [5:0]  SEG_LAST   = 6'd62;
  localparam logic [5:0]  CELLS_RST  = 6'd32;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

// ===== rtl/rgst_edge_mem.sv =====
// ----------------------------------------------------------------------------
// rgst_edge_mem: grid edge store
// One write port, one registered read port; edge zero always reads as zero.
// ----------------------------------------------------------------------------
module rgst_edge_mem #(
  parameter int DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;
  logic        zero_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
    zero_q  <= (raddr_i == '0);
  end

  // edge zero is never written
  assign rdata_o = zero_q ? 32'd0 : rdata_q;

endmodule

// ===== rtl/rgst_div.sv =====
// ----------------------------------------------------------------------------
// rgst_div: iterative divider
// 65-bit by 32-bit restoring division, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module rgst_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [64:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic [6:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [64:0] dvd_q;
  logic [31:0] dsr_q;
  logic [31:0] rem_q;
  logic [64:0] quo_q;
  logic [32:0] shifted;
  logic        ge;

  assign shifted = {rem_q, dvd_q[64]};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      dvd_q  <= '0;
      dsr_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(rgst_pkg::DIV_STEPS);
        dvd_q  <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? 32'(shifted - {1'b0, dsr_q}) : shifted[31:0];
        quo_q <= {quo_q[63:0], ge};
        dvd_q <= {dvd_q[63:0], 1'b0};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = (|quo_q[64:32]) ? 32'hFFFF_FFFF : quo_q[31:0];

endmodule

// ===== rtl/rgst_sqrt.sv =====
// ----------------------------------------------------------------------------
// rgst_sqrt: iterative integer square root
// Floor root of a 65-bit radicand, two radicand bits per cycle, saturated.
// ----------------------------------------------------------------------------
module rgst_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [64:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [65:0] rad_q;
  logic [36:0] rem_q;
  logic [32:0] root_q;
  logic [36:0] rem_sh;
  logic [36:0] trial;
  logic        ge;

  assign rem_sh = {rem_q[34:0], rad_q[65:64]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(rgst_pkg::SQRT_STEPS);
        rad_q  <= {1'b0, radicand_i};
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rem_q  <= ge ? (rem_sh - trial) : rem_sh;
        root_q <= {root_q[31:0], ge};
        rad_q  <= {rad_q[63:0], 2'b00};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[32] ? 32'hFFFF_FFFF : root_q[31:0];

endmodule

// ===== rtl/ray_grid_segment_tracer_top.sv =====
// ----------------------------------------------------------------------------
// ray_grid_segment_tracer_top: ray tracer over a rectangular cell grid
// Keeps x and y edge positions in two memories and walks a track through the
// grid, giving one item per cell crossed: region, length and a last flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries commands: load an x or y
//   cell width (edge k+1 = edge k + width, saturating) or trace an upward
//   track from its entry to its exit point. A trace first scans the edge
//   memories for the start cell, then per segment reads both memories, forms
//   two cross products, does an optional 65-step division, squares two sides
//   and takes a 33-step square root, for up to 63 segments.
//   Output channel (out_valid_o / out_stall_i) is a single output register;
//   a stalled segment holds, and the walk waits at its next segment.
//   A new input item is taken once the previous trace has handed its last
//   segment to the output register, even while that segment still waits.
//   Config port (cfg_we_i, cfg_index_i, cfg_data_i) sets cells in use; write
//   it only while idle. Reset sets both sizes to 32 and empties the channels;
//   edge memories hold no reset value and must be loaded before tracing.
// ----------------------------------------------------------------------------
module ray_grid_segment_tracer_top #(
  parameter int MAX_CELLS_X = 32,
  parameter int MAX_CELLS_Y = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  cell_index_i,
  input  logic [31:0] cell_width_i,
  input  logic [31:0] enter_x_i,
  input  logic [31:0] enter_y_i,
  input  logic [31:0] exit_x_i,
  input  logic [31:0] exit_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  region_o,
  output logic [31:0] seg_length_o,
  output logic        last_o
);

  localparam int XAW = $clog2(MAX_CELLS_X + 1);
  localparam int YAW = $clog2(MAX_CELLS_Y + 1);
  localparam int XCW = $clog2(MAX_CELLS_X + 2);
  localparam int YCW = $clog2(MAX_CELLS_Y + 2);

  typedef enum logic [4:0] {
    S_IDLE, S_LD_WR, S_SX_RD, S_SX_CK, S_SY_RD, S_SY_CK, S_BASE,
    S_RD, S_T, S_M1, S_M2, S_CMP, S_DIV, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_EMIT
  } state_e;

  typedef enum logic [1:0] {X_TOP, X_SIDE, X_CORNER} cross_e;

  state_e            state_q;
  rgst_pkg::cmd_e    cmd_q;
  cross_e            kind_q;
  logic [5:0]        cells_x_q, cells_y_q;
  logic [4:0]        idx_q;
  logic [31:0]       w_q, ex_q, ey_q, dy_q, adx_q, px_q, py_q;
  logic [31:0]       xe_q, ye_q, tx_q, ty_q, ha_q, hb_q;
  logic [63:0]       lhs_q, rhs_q;
  logic              left_q;
  logic [XCW-1:0]    nx_q, sx_q, col_q;
  logic [YCW-1:0]    ny_q, sy_q, row_q;
  logic [9:0]        base_q;
  logic [5:0]        n_q;
  logic              out_valid_q, last_q;
  logic [9:0]        region_q;
  logic [31:0]       seg_q;

  // memories
  logic              x_we, y_we;
  logic [XAW-1:0]    x_waddr, x_raddr;
  logic [YAW-1:0]    y_waddr, y_raddr;
  logic [31:0]       x_rd, y_rd, ld_data;

  // shared multiplier
  logic [31:0]       ma, mb;
  logic [63:0]       prod;

  // iterative units
  logic              div_start, div_done, sqrt_start, sqrt_done;
  logic [64:0]       div_dvd, rad;
  logic [31:0]       div_dsr, div_quo, root;

  // emit step
  logic              mx, my, x_out, y_out, seg_done;
  logic              in_acc, cmd_ok;
  logic [XCW-1:0]    c_hit;

  rgst_edge_mem #(.DEPTH(MAX_CELLS_X + 1)) u_x_mem (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(ld_data),
    .raddr_i(x_raddr), .rdata_o(x_rd)
  );

  rgst_edge_mem #(.DEPTH(MAX_CELLS_Y + 1)) u_y_mem (
    .clk_i, .we_i(y_we), .waddr_i(y_waddr), .wdata_i(ld_data),
    .raddr_i(y_raddr), .rdata_o(y_rd)
  );

  rgst_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i(div_dsr), .done_o(div_done), .quotient_o(div_quo)
  );

  rgst_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .radicand_i(rad),
    .done_o(sqrt_done), .root_o(root)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);

  // edge loads: read edge k while accepting, write edge k+1 next cycle
  assign ld_data = rgst_pkg::sat_add(cmd_q == rgst_pkg::CMD_LOAD_X ? x_rd : y_rd, w_q);
  assign x_we    = (state_q == S_LD_WR) && (cmd_q == rgst_pkg::CMD_LOAD_X);
  assign y_we    = (state_q == S_LD_WR) && (cmd_q == rgst_pkg::CMD_LOAD_Y);
  assign x_waddr = XAW'({1'b0, idx_q} + 6'd1);
  assign y_waddr = YAW'({1'b0, idx_q} + 6'd1);

  always_comb begin
    x_raddr = '0;
    y_raddr = '0;
    case (state_q)
      S_IDLE: begin
        x_raddr = XAW'(cell_index_i);
        y_raddr = YAW'(cell_index_i);
      end
      S_SX_RD: x_raddr = XAW'(sx_q);
      S_SY_RD: y_raddr = YAW'(sy_q);
      S_RD: begin
        x_raddr = left_q ? XAW'(col_q) : XAW'(col_q + XCW'(1));
        y_raddr = YAW'(row_q + YCW'(1));
      end
      default: ;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state_q)
      S_BASE: begin
        ma = 32'(row_q);
        mb = 32'(nx_q);
      end
      S_M1: begin
        ma = tx_q;
        mb = dy_q;
      end
      S_M2: begin
        ma = ty_q;
        mb = adx_q;
      end
      S_SQ1: begin
        ma = ha_q;
        mb = ha_q;
      end
      S_SQ2: begin
        ma = hb_q;
        mb = hb_q;
      end
      default: ;
    endcase
  end
  assign prod = ma * mb;

  // top crossing divides by dy, side crossing by |dx|; products are reused
  assign div_start  = (state_q == S_CMP) && (lhs_q != rhs_q);
  assign div_dvd    = (lhs_q > rhs_q) ? ({1'b0, rhs_q} + 65'(dy_q >> 1))
                                      : ({1'b0, lhs_q} + 65'(adx_q >> 1));
  assign div_dsr    = (lhs_q > rhs_q) ? dy_q : adx_q;
  assign sqrt_start = (state_q == S_SQ3);
  assign rad        = {1'b0, lhs_q} + {1'b0, rhs_q};

  assign cmd_ok = (command_i == rgst_pkg::CMD_LOAD_X && 32'(cell_index_i) < MAX_CELLS_X)
               || (command_i == rgst_pkg::CMD_LOAD_Y && 32'(cell_index_i) < MAX_CELLS_Y);

  assign c_hit = (x_rd == ex_q && !left_q) ? sx_q : sx_q - XCW'(1);

  assign mx       = (kind_q != X_TOP);
  assign my       = (kind_q != X_SIDE);
  assign x_out    = mx && (left_q ? (col_q == '0) : ((col_q + XCW'(1)) >= nx_q));
  assign y_out    = my && ((row_q + YCW'(1)) >= ny_q);
  assign seg_done = x_out || y_out || (n_q == rgst_pkg::SEG_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= rgst_pkg::CMD_NONE;
      kind_q      <= X_CORNER;
      cells_x_q   <= rgst_pkg::CELLS_RST;
      cells_y_q   <= rgst_pkg::CELLS_RST;
      idx_q       <= '0;
      w_q         <= '0;
      ex_q        <= '0;
      ey_q        <= '0;
      dy_q        <= '0;
      adx_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      xe_q        <= '0;
      ye_q        <= '0;
      tx_q        <= '0;
      ty_q        <= '0;
      ha_q        <= '0;
      hb_q        <= '0;
      lhs_q       <= '0;
      rhs_q       <= '0;
      left_q      <= 1'b0;
      nx_q        <= '0;
      ny_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      col_q       <= '0;
      row_q       <= '0;
      base_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      region_q    <= '0;
      seg_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rgst_pkg::REG_CELLS_X: cells_x_q <= cfg_data_i;
          rgst_pkg::REG_CELLS_Y: cells_y_q <= cfg_data_i;
          default: ;
        endcase
      end

      // emit refills the register itself
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q  <= rgst_pkg::cmd_e'(command_i);
            idx_q  <= cell_index_i;
            w_q    <= cell_width_i;
            ex_q   <= enter_x_i;
            ey_q   <= enter_y_i;
            px_q   <= enter_x_i;
            py_q   <= enter_y_i;
            dy_q   <= exit_y_i - enter_y_i;
            left_q <= exit_x_i < enter_x_i;
            adx_q  <= (exit_x_i < enter_x_i) ? enter_x_i - exit_x_i : exit_x_i - enter_x_i;
            n_q    <= '0;
            sx_q   <= XCW'(1);
            sy_q   <= YCW'(1);
            if (cells_x_q == '0) begin
              nx_q <= XCW'(1);
            end else if (32'(cells_x_q) > MAX_CELLS_X) begin
              nx_q <= XCW'(MAX_CELLS_X);
            end else begin
              nx_q <= XCW'(cells_x_q);
            end
            if (cells_y_q == '0) begin
              ny_q <= YCW'(1);
            end else if (32'(cells_y_q) > MAX_CELLS_Y) begin
              ny_q <= YCW'(MAX_CELLS_Y);
            end else begin
              ny_q <= YCW'(cells_y_q);
            end
            if (cmd_ok) begin
              state_q <= S_LD_WR;
            end else if (command_i == rgst_pkg::CMD_TRACE && exit_y_i > enter_y_i) begin
              state_q <= S_SX_RD;
            end
          end
        end
        S_LD_WR: state_q <= S_IDLE;
        // start column: first edge at or above the entry x
        S_SX_RD: begin
          if (sx_q > nx_q) begin
            col_q   <= nx_q - XCW'(1);
            state_q <= S_SY_RD;
          end else begin
            state_q <= S_SX_CK;
          end
        end
        S_SX_CK: begin
          if (x_rd >= ex_q) begin
            col_q   <= (c_hit > nx_q - XCW'(1)) ? nx_q - XCW'(1) : c_hit;
            state_q <= S_SY_RD;
          end else begin
            sx_q    <= sx_q + XCW'(1);
            state_q <= S_SX_RD;
          end
        end
        // start row: first edge above the entry y
        S_SY_RD: begin
          if (sy_q > ny_q) begin
            row_q   <= ny_q - YCW'(1);
            state_q <= S_BASE;
          end else begin
            state_q <= S_SY_CK;
          end
        end
        S_SY_CK: begin
          if (y_rd > ey_q) begin
            row_q   <= sy_q - YCW'(1);
            state_q <= S_BASE;
          end else begin
            sy_q    <= sy_q + YCW'(1);
            state_q <= S_SY_RD;
          end
        end
        S_BASE: begin
          base_q  <= prod[9:0];
          state_q <= S_RD;
        end
        S_RD: state_q <= S_T;
        S_T: begin
          xe_q    <= x_rd;
          ye_q    <= y_rd;
          tx_q    <= left_q ? rgst_pkg::sat_sub(px_q, x_rd) : rgst_pkg::sat_sub(x_rd, px_q);
          ty_q    <= rgst_pkg::sat_sub(y_rd, py_q);
          state_q <= S_M1;
        end
        S_M1: begin
          lhs_q   <= prod;
          state_q <= S_M2;
        end
        S_M2: begin
          rhs_q   <= prod;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (lhs_q > rhs_q) begin
            kind_q  <= X_TOP;
            ha_q    <= ty_q;
            state_q <= S_DIV;
          end else if (lhs_q < rhs_q) begin
            kind_q  <= X_SIDE;
            ha_q    <= tx_q;
            state_q <= S_DIV;
          end else begin
            kind_q  <= X_CORNER;
            ha_q    <= tx_q;
            hb_q    <= ty_q;
            state_q <= S_SQ1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            hb_q    <= div_quo;
            state_q <= S_SQ1;
          end
        end
        S_SQ1: begin
          lhs_q   <= prod;
          state_q <= S_SQ2;
        end
        S_SQ2: begin
          rhs_q   <= prod;
          state_q <= S_SQ3;
        end
        S_SQ3: state_q <= S_SQRT;
        S_SQRT: begin
          if (sqrt_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            region_q    <= 10'(col_q) + base_q;
            seg_q       <= root;
            last_q      <= seg_done;
            n_q         <= n_q + 6'd1;
            if (kind_q == X_TOP) begin
              px_q <= left_q ? rgst_pkg::sat_sub(px_q, hb_q) : rgst_pkg::sat_add(px_q, hb_q);
            end else begin
              px_q <= xe_q;
            end
            if (kind_q == X_SIDE) begin
              py_q <= rgst_pkg::sat_add(py_q, hb_q);
            end else begin
              py_q <= ye_q;
            end
            if (mx) begin
              col_q <= left_q ? col_q - XCW'(1) : col_q + XCW'(1);
            end
            if (my) begin
              row_q  <= row_q + YCW'(1);
              base_q <= base_q + 10'(nx_q);
            end
            state_q <= seg_done ? S_IDLE : S_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign region_o     = region_q;
  assign seg_length_o = seg_q;
  assign last_o       = last_q;

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished outside its wait state");

  a_sqrt_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRT)
    else $error("square root finished outside its wait state");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EMIT))
    else $error("output item raised outside emit");

endmodule

// ===== verif/ray_grid_segment_tracer_top_tb.sv =====
// ----------------------------------------------------------------------------
// ray_grid_segment_tracer_top_tb: self-checking bench of the segment tracer
// Loads cell widths, traces directed and random tracks over several grid
// sizes and compares every segment with a bit-exact walk kept in the bench.
// ----------------------------------------------------------------------------
module ray_grid_segment_tracer_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] ONE_CELL   = 32'h0001_0000;
  localparam int          SEG_MAX    = 63;
  localparam int          SETTLE_CYC = 300;    // covers a start-cell scan
  localparam int          WDOG_LIMIT = 20000;  // cycles with no item moving

  typedef struct {
    rgst_pkg::cmd_e cmd;
    logic [4:0]     idx;
    logic [31:0]    width;
    logic [31:0]    ex, ey, xx, xy;
  } track_cmd_t;

  typedef struct {
    logic [9:0]  region;
    logic [31:0] length;
    logic        last;
  } segment_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = '0;
  logic [5:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = '0;
  logic [4:0]  cell_index_i = '0;
  logic [31:0] cell_width_i = '0;
  logic [31:0] enter_x_i = '0;
  logic [31:0] enter_y_i = '0;
  logic [31:0] exit_x_i = '0;
  logic [31:0] exit_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [9:0]  region_o;
  logic [31:0] seg_length_o;
  logic        last_o;

  ray_grid_segment_tracer_top uut (.*);

  always #1 clk_i = ~clk_i;

  // Bench copy of the grid state, updated when an item is accepted.
  logic [31:0] x_edge_mdl [0:32];
  logic [31:0] y_edge_mdl [0:32];
  logic [5:0]  cells_x_mdl = rgst_pkg::CELLS_RST;
  logic [5:0]  cells_y_mdl = rgst_pkg::CELLS_RST;

  track_cmd_t  pending_q [$];
  segment_t    segment_q [$];
  int          mismatches = 0;
  int          in_gap = 0;
  int          out_hold = 0;
  int          wdog = 0;
  bit          quiet = 1'b0;

  initial begin
    for (int k = 0; k <= 32; k++) begin
      x_edge_mdl[k] = '0;
      y_edge_mdl[k] = '0;
    end
  end

  function automatic logic [31:0] add_clip(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? ALL_ONES : s[31:0];
  endfunction

  function automatic logic [31:0] sub_floor(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  // (t*num + den/2) / den, clipped to 32 bits
  function automatic logic [31:0] round_div(logic [31:0] t, logic [31:0] num,
                                            logic [31:0] den);
    logic [64:0] p;
    p = 65'(t) * 65'(num) + 65'(den >> 1);
    p = p / 65'(den);
    return (p > 65'(ALL_ONES)) ? ALL_ONES : p[31:0];
  endfunction

  // floor(sqrt(a*a + b*b)), clipped to 32 bits
  function automatic logic [31:0] hypot_floor(logic [31:0] a, logic [31:0] b);
    logic [66:0] s, c, r;
    s = 67'(a) * 67'(a) + 67'(b) * 67'(b);
    r = '0;
    for (int b_i = 32; b_i >= 0; b_i--) begin
      c = r | (67'(1) << b_i);
      if (c * c <= s) r = c;
    end
    return (r > 67'(ALL_ONES)) ? ALL_ONES : r[31:0];
  endfunction

  function automatic int clamp_cells(logic [5:0] c);
    if (c == 0) return 1;
    if (c > 32) return 32;
    return int'(c);
  endfunction

  // Apply one accepted item to the bench state and queue its segments.
  task automatic walk_track(track_cmd_t it);
    logic [31:0] dy, adx, px, py, tx, ty, adv, len;
    logic [63:0] lhs, rhs;
    segment_t    sg;
    int          nx, ny, i, j;
    bit          left, done;
    if (it.cmd == rgst_pkg::CMD_LOAD_X) begin
      x_edge_mdl[int'(it.idx) + 1] = add_clip(x_edge_mdl[it.idx], it.width);
      return;
    end
    if (it.cmd == rgst_pkg::CMD_LOAD_Y) begin
      y_edge_mdl[int'(it.idx) + 1] = add_clip(y_edge_mdl[it.idx], it.width);
      return;
    end
    if (it.cmd != rgst_pkg::CMD_TRACE || it.xy <= it.ey) return;
    dy   = it.xy - it.ey;
    left = it.xx < it.ex;
    adx  = left ? it.ex - it.xx : it.xx - it.ex;
    nx   = clamp_cells(cells_x_mdl);
    ny   = clamp_cells(cells_y_mdl);
    // start column: first edge at or past the entry point
    for (i = 1; i <= nx; i++) begin
      if (x_edge_mdl[i] == it.ex) begin
        if (left) i--;
        break;
      end
      if (x_edge_mdl[i] > it.ex) begin
        i--;
        break;
      end
    end
    if (i > nx - 1) i = nx - 1;
    for (j = 1; j <= ny; j++) begin
      if (y_edge_mdl[j] > it.ey) begin
        j--;
        break;
      end
    end
    if (j > ny - 1) j = ny - 1;
    px = it.ex;
    py = it.ey;
    for (int n = 0; n < SEG_MAX; n++) begin
      sg.region = 10'(i + j * nx);
      tx  = left ? sub_floor(px, x_edge_mdl[i]) : sub_floor(x_edge_mdl[i + 1], px);
      ty  = sub_floor(y_edge_mdl[j + 1], py);
      lhs = 64'(tx) * 64'(dy);
      rhs = 64'(ty) * 64'(adx);
      if (lhs > rhs) begin
        // top crossing
        adv = round_div(ty, adx, dy);
        px  = left ? sub_floor(px, adv) : add_clip(px, adv);
        py  = y_edge_mdl[j + 1];
        j++;
        len = hypot_floor(ty, adv);
      end else if (lhs < rhs) begin
        // side crossing
        adv = round_div(tx, dy, adx);
        py  = add_clip(py, adv);
        if (left) begin
          px = x_edge_mdl[i];
          i--;
        end else begin
          px = x_edge_mdl[i + 1];
          i++;
        end
        len = hypot_floor(tx, adv);
      end else begin
        // exact corner
        if (left) begin
          px = x_edge_mdl[i];
          i--;
        end else begin
          px = x_edge_mdl[i + 1];
          i++;
        end
        py = y_edge_mdl[j + 1];
        j++;
        len = hypot_floor(tx, ty);
      end
      done = (i < 0 || i >= nx || j >= ny || n == SEG_MAX - 1);
      sg.length = len;
      sg.last   = done;
      segment_q.push_back(sg);
      if (done) break;
    end
  endtask

  // Input driver: holds an item until taken, random idle bursts in between.
  always @(posedge clk_i) begin
    automatic bit busy = in_valid_i;
    automatic bit nv = 1'b0;
    if (in_valid_i && !in_stall_o) begin
      walk_track(pending_q.pop_front());
      busy = 1'b0;
    end
    if (!busy) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_q.size() > 0 && (quiet || $urandom_range(0, 3) != 0)) begin
        nv           = 1'b1;
        command_i    <= pending_q[0].cmd;
        cell_index_i <= pending_q[0].idx;
        cell_width_i <= pending_q[0].width;
        enter_x_i    <= pending_q[0].ex;
        enter_y_i    <= pending_q[0].ey;
        exit_x_i     <= pending_q[0].xx;
        exit_y_i     <= pending_q[0].xy;
      end else if (pending_q.size() > 0) begin
        in_gap = $urandom_range(0, 9);
      end
      in_valid_i <= nv;
    end
  end

  // Output monitor: compares each taken segment, stalls in random bursts.
  always @(posedge clk_i) begin
    automatic bit stall = 1'b0;
    automatic segment_t want;
    if (out_valid_o && !out_stall_i) begin
      if (segment_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected segment region=%0d len=%h last=%b",
                   region_o, seg_length_o, last_o);
      end else begin
        want = segment_q.pop_front();
        if (region_o !== want.region || seg_length_o !== want.length ||
            last_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("segment mismatch: exp region=%0d len=%h last=%b, got %0d %h %b",
                     want.region, want.length, want.last,
                     region_o, seg_length_o, last_o);
        end
      end
    end
    if (out_hold > 0) begin
      out_hold--;
      stall = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 9);
      stall = 1'b1;
    end
    out_stall_i <= stall;
  end

  // Watchdog on cycles where no item moves on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("ray_grid_segment_tracer_top verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_i || segment_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(rgst_pkg::reg_e r, logic [5:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (r == rgst_pkg::REG_CELLS_X) cells_x_mdl = v;
    else cells_y_mdl = v;
  endtask

  task automatic set_grid(logic [5:0] cx, logic [5:0] cy);
    wait_idle();
    write_reg(rgst_pkg::REG_CELLS_X, cx);
    write_reg(rgst_pkg::REG_CELLS_Y, cy);
  endtask

  task automatic push_item(rgst_pkg::cmd_e c, logic [4:0] idx, logic [31:0] w,
                           logic [31:0] ex, logic [31:0] ey,
                           logic [31:0] xx, logic [31:0] xy);
    track_cmd_t it;
    it.cmd = c; it.idx = idx; it.width = w;
    it.ex = ex; it.ey = ey; it.xx = xx; it.xy = xy;
    pending_q.push_back(it);
  endtask

  // Widths loaded in increasing cell order; other fields carry junk.
  task automatic push_loads(rgst_pkg::cmd_e c, int count, logic [31:0] lo,
                            logic [31:0] hi);
    for (int k = 0; k < count; k++)
      push_item(c, 5'(k), $urandom_range(hi, lo), $urandom, $urandom,
                $urandom, $urandom);
  endtask

  // Random tracks over the current grid, mostly inside and upward.
  task automatic push_tracks(int count);
    logic [31:0] xe, ye, ex, ey, xx;
    logic [32:0] top;
    wait_idle();
    xe = x_edge_mdl[clamp_cells(cells_x_mdl)];
    ye = y_edge_mdl[clamp_cells(cells_y_mdl)];
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: push_item(rgst_pkg::CMD_TRACE, 5'($urandom), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        1: begin
          ey = $urandom_range(ALL_ONES, 0);
          push_item(rgst_pkg::CMD_TRACE, 5'($urandom), $urandom, $urandom, ey,
                    $urandom, $urandom_range(ey, 0));
        end
        2: push_item(rgst_pkg::cmd_e'($urandom_range(3, 0)), 5'($urandom), $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        default: begin
          ex  = $urandom_range(xe, 0);
          ey  = $urandom_range(ye, 0);
          xx  = ($urandom_range(0, 7) == 0) ? ex : $urandom_range(xe, 0);
          top = 33'(ey) + 33'd1 + 33'($urandom_range(ye, 0));
          if (ey == ALL_ONES) ey = ALL_ONES - 1;
          push_item(rgst_pkg::CMD_TRACE, 5'($urandom), $urandom, ex, ey, xx,
                    top[32] ? ALL_ONES : top[31:0]);
        end
      endcase
    end
  endtask

  initial begin
    logic [5:0] cx, cy;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: 4x4 grid of unit cells.
    set_grid(6'd4, 6'd4);
    for (int k = 0; k < 4; k++) begin
      push_item(rgst_pkg::CMD_LOAD_X, 5'(k), ONE_CELL, '0, '0, '0, '0);
      push_item(rgst_pkg::CMD_LOAD_Y, 5'(k), ONE_CELL, '0, '0, '0, '0);
    end
    // diagonal through corners
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h0, 32'h0, 32'h4_0000, 32'h4_0000);
    // vertical
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h1_8000, 32'h0, 32'h1_8000, 32'h5_0000);
    // going left, steeper than the diagonal
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h3_8000, 32'h8000, 32'h0_4000, 32'h4_8000);
    // going left from an edge point
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h2_0000, 32'h0, 32'h0, 32'h1_0000);
    // not upward, flat and downward
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h2_0000);
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h1_0000, 32'h3_0000, 32'h3_0000, 32'h1_0000);
    // unused command
    push_item(rgst_pkg::CMD_NONE, 5'h1F, ALL_ONES, ALL_ONES, '0, '0, ALL_ONES);
    // extreme end points, some starting outside the grid
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h0, 32'h0, ALL_ONES, ALL_ONES);
    push_item(rgst_pkg::CMD_TRACE, '0, '0, ALL_ONES, 32'h0, 32'h0, 32'h1);
    push_item(rgst_pkg::CMD_TRACE, '0, '0, ALL_ONES, ALL_ONES - 1, ALL_ONES, ALL_ONES);
    push_item(rgst_pkg::CMD_TRACE, '0, '0, 32'h0, 32'h0, 32'h0, ALL_ONES);

    // Full 32x32 grid of small cells.
    set_grid(6'd32, 6'd32);
    push_loads(rgst_pkg::CMD_LOAD_X, 32, 32'h800, 32'h2_0000);
    push_loads(rgst_pkg::CMD_LOAD_Y, 32, 32'h800, 32'h2_0000);
    push_tracks(10);

    // Zero sizes act as a single cell.
    set_grid(6'd0, 6'd0);
    push_tracks(5);

    // Oversize x, single row, first x widths over the whole range (saturating sums).
    set_grid(6'd63, 6'd1);
    push_item(rgst_pkg::CMD_LOAD_X, 5'd0, 32'h0, '0, '0, '0, '0);
    push_loads(rgst_pkg::CMD_LOAD_X, 4, 32'h0, ALL_ONES);
    push_tracks(6);

    // Random small sizes; the last round runs without idling.
    for (int r = 0; r < 2; r++) begin
      cx = 6'($urandom_range(8, 1));
      cy = 6'($urandom_range(8, 1));
      set_grid(cx, cy);
      if (r == 1) quiet = 1'b1;
      push_loads(rgst_pkg::CMD_LOAD_X, int'(cx), 32'h1000, 32'h4_0000);
      push_loads(rgst_pkg::CMD_LOAD_Y, int'(cy), 32'h1000, 32'h4_0000);
      push_tracks(5);
    end

    wait_idle();
    if (mismatches == 0 && segment_q.size() == 0)
      $display("ray_grid_segment_tracer_top verification clean");
    else
      $display("ray_grid_segment_tracer_top verification failed");
    $finish;
  end

endmodule

// ===== ray_grid_segment_tracer_top.f =====
rtl/rgst_pkg.sv
rtl/rgst_edge_mem.sv
rtl/rgst_div.sv
rtl/rgst_sqrt.sv
rtl/ray_grid_segment_tracer_top.sv
verif/ray_grid_segment_tracer_top_tb.sv
